### design/i2a_pkg.sv
// Shared types, constants and helpers for the integer to ASCII formatter.
package i2a_pkg;

    localparam int VALUE_BITS_DEF = 32;
    localparam int MAX_WIDTH_DEF  = 63;
    localparam int MAX_RESULTS    = 63;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h41;

    typedef enum logic [1:0] {
        RADIX_BIN = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_DEC = 2'd2,
        RADIX_HEX = 2'd3
    } radix_t;

    typedef enum logic [1:0] {
        SEL_SIGN  = 2'd0,
        SEL_PAD   = 2'd1,
        SEL_DIGIT = 2'd2
    } char_sel_t;

    typedef struct packed {
        logic [31:0] value;
        logic [1:0]  radix_code;
        logic        signed_mode;
        logic [5:0]  min_width;
        logic [7:0]  pad_char;
    } in_req_t;

    typedef struct packed {
        logic [7:0] text_char;
        logic       last;
    } out_req_t;

    typedef struct packed {
        logic      load;
        logic      extract;
        logic      prep;
        logic      rd;
        logic      emit;
        char_sel_t sel;
        logic      last;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic neg;
        logic pad_zero;
        logic rd_zero;
        logic cnt_limit;
        logic out_free;
    } status_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] d8;
        d8 = {4'd0, d};
        if (d < 4'd10) begin
            return CHAR_ZERO + d8;
        end
        return CHAR_A + d8 - 8'd10;
    endfunction

endpackage

### design/i2a_ram.sv
// Generic single write port, single read port RAM with registered read data.
module i2a_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### design/i2a_ctrl.sv
// Sequencing state machine for the formatter: extraction, sign, padding, digits.
module i2a_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  i2a_pkg::status_t sts,
    output i2a_pkg::cmd_t   cmd
);
    import i2a_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_EXTRACT = 7'b0000010,
        ST_PREP    = 7'b0000100,
        ST_SIGN    = 7'b0001000,
        ST_PAD     = 7'b0010000,
        ST_FETCH   = 7'b0100000,
        ST_SEND    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.extract = 1'b0;
        cmd.prep    = 1'b0;
        cmd.rd      = 1'b0;
        cmd.emit    = 1'b0;
        cmd.sel     = SEL_DIGIT;
        cmd.last    = sts.cnt_limit;
        s_ready     = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXTRACT;
                end
            end
            ST_EXTRACT: begin
                cmd.extract = 1'b1;
                if (sts.div_done) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = sts.neg ? ST_SIGN : ST_PAD;
            end
            ST_SIGN: begin
                cmd.sel = SEL_SIGN;
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = sts.cnt_limit ? ST_IDLE : ST_PAD;
                end
            end
            ST_PAD: begin
                cmd.sel = SEL_PAD;
                if (sts.pad_zero) begin
                    state_next = ST_FETCH;
                end else if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.cnt_limit) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FETCH: begin
                cmd.rd     = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND: begin
                cmd.sel  = SEL_DIGIT;
                cmd.last = sts.cnt_limit | sts.rd_zero;
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = cmd.last ? ST_IDLE : ST_FETCH;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

### design/i2a_dpath.sv
// Datapath: digit extraction by radix, digit store, pad count and output register.
module i2a_dpath #(
    parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF,
    parameter int MAX_WIDTH  = i2a_pkg::MAX_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  i2a_pkg::in_req_t  s_data,
    input  i2a_pkg::cmd_t     cmd,
    output i2a_pkg::status_t  sts,
    input  logic              m_ready,
    output logic              m_valid,
    output i2a_pkg::out_req_t m_data
);
    import i2a_pkg::*;

    localparam int DIV_W  = ((VALUE_BITS + 7) / 8) * 8;
    localparam int STEPS  = DIV_W / 8;
    localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam int AW     = $clog2(VALUE_BITS);
    localparam int NDIG_W = $clog2(VALUE_BITS + 1);

    logic [DIV_W-1:0]  w_reg;
    logic [3:0]        rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NDIG_W-1:0] ndig_reg;
    logic [AW-1:0]     rd_ptr_reg;
    logic [5:0]        width_reg;
    logic [5:0]        pad_reg;
    logic [5:0]        cnt_reg;
    logic [7:0]        pad_char_reg;
    radix_t            radix_reg;
    logic              neg_reg;
    logic              m_valid_reg;
    out_req_t          m_data_reg;

    // load-time values
    logic [VALUE_BITS-1:0] v_in;
    logic                  neg_in;
    logic [VALUE_BITS-1:0] mag_in;
    logic [5:0]            width_sat;

    // one decimal step: eight bits of long division by ten
    logic [DIV_W-1:0] w_dec;
    logic [3:0]       rem_dec;
    logic             final_step;

    // power-of-two radix: one digit a cycle
    logic [DIV_W-1:0] w_p2;
    logic [3:0]       dig_p2;

    logic             digit_now;
    logic [DIV_W-1:0] w_after;
    logic [3:0]       dig_wr;
    logic [3:0]       rd_digit;
    logic [6:0]       ndig_ext;
    logic [7:0]       char_sel;

    assign v_in   = VALUE_BITS'(s_data.value);
    assign neg_in = s_data.signed_mode & v_in[VALUE_BITS-1];
    assign mag_in = neg_in ? (~v_in + 1'b1) : v_in;

    always_comb begin
        if (s_data.min_width > 6'(MAX_WIDTH)) begin
            width_sat = 6'(MAX_WIDTH);
        end else begin
            width_sat = s_data.min_width;
        end
        if (neg_in && (width_sat != 6'd0)) begin
            width_sat = width_sat - 6'd1;
        end
    end

    always_comb begin
        logic [4:0] r5;
        logic [3:0] r;
        logic [DIV_W-1:0] ww;
        r  = rem_reg;
        ww = w_reg;
        for (int i = 0; i < 8; i++) begin
            r5 = {r, ww[DIV_W-1]};
            ww = {ww[DIV_W-2:0], 1'b0};
            if (r5 >= 5'd10) begin
                r     = 4'(r5 - 5'd10);
                ww[0] = 1'b1;
            end else begin
                r = r5[3:0];
            end
        end
        w_dec   = ww;
        rem_dec = r;
    end

    assign final_step = (step_reg == STEP_W'(STEPS - 1));

    always_comb begin
        case (radix_reg)
            RADIX_BIN: begin
                w_p2   = w_reg >> 1;
                dig_p2 = {3'd0, w_reg[0]};
            end
            RADIX_OCT: begin
                w_p2   = w_reg >> 3;
                dig_p2 = {1'b0, w_reg[2:0]};
            end
            RADIX_HEX: begin
                w_p2   = w_reg >> 4;
                dig_p2 = w_reg[3:0];
            end
            default: begin
                w_p2   = w_reg;
                dig_p2 = 4'd0;
            end
        endcase
    end

    assign digit_now = (radix_reg != RADIX_DEC) || final_step;
    assign w_after   = (radix_reg == RADIX_DEC) ? w_dec : w_p2;
    assign dig_wr    = (radix_reg == RADIX_DEC) ? rem_dec : dig_p2;
    assign ndig_ext  = 7'(ndig_reg);

    i2a_ram #(
        .WIDTH(4),
        .DEPTH(VALUE_BITS)
    ) u_digits (
        .aclk (aclk),
        .we   (cmd.extract & digit_now),
        .waddr(ndig_reg[AW-1:0]),
        .wdata(dig_wr),
        .re   (cmd.rd),
        .raddr(rd_ptr_reg),
        .rdata(rd_digit)
    );

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            w_reg        <= DIV_W'(mag_in);
            rem_reg      <= 4'd0;
            step_reg     <= '0;
            ndig_reg     <= '0;
            cnt_reg      <= 6'd0;
            width_reg    <= width_sat;
            pad_char_reg <= s_data.pad_char;
            radix_reg    <= radix_t'(s_data.radix_code);
            neg_reg      <= neg_in;
        end
        if (cmd.extract) begin
            w_reg <= w_after;
            if (digit_now) begin
                rem_reg  <= 4'd0;
                step_reg <= '0;
                ndig_reg <= ndig_reg + 1'b1;
            end else begin
                rem_reg  <= rem_dec;
                step_reg <= step_reg + 1'b1;
            end
        end
        if (cmd.prep) begin
            rd_ptr_reg <= AW'(ndig_reg - 1'b1);
            if (ndig_ext < {1'b0, width_reg}) begin
                pad_reg <= 6'({1'b0, width_reg} - ndig_ext);
            end else begin
                pad_reg <= 6'd0;
            end
        end
        if (cmd.emit) begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cmd.sel == SEL_PAD) begin
                pad_reg <= pad_reg - 6'd1;
            end
            if (cmd.sel == SEL_DIGIT) begin
                rd_ptr_reg <= rd_ptr_reg - 1'b1;
            end
            m_data_reg.text_char <= char_sel;
            m_data_reg.last      <= cmd.last;
        end
    end

    always_comb begin
        case (cmd.sel)
            SEL_SIGN:  char_sel = CHAR_MINUS;
            SEL_PAD:   char_sel = pad_char_reg;
            SEL_DIGIT: char_sel = digit_char(rd_digit);
            default:   char_sel = digit_char(rd_digit);
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign sts.div_done  = digit_now && (w_after == '0);
    assign sts.neg       = neg_reg;
    assign sts.pad_zero  = (pad_reg == 6'd0);
    assign sts.rd_zero   = (rd_ptr_reg == '0);
    assign sts.cnt_limit = (cnt_reg == 6'(MAX_RESULTS - 1));
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

### design/integer_to_ascii_formatter_unit.sv
// Top level of the integer to ASCII formatter: controller, datapath and digit store.
// Sequence: load in idle, digit extraction (decimal by long division for each digit,
//   binary/octal/hex one digit a cycle), padding set-up, then the first character.
// Flow: one request at a time; sign and pads one a cycle while the output is free, then a
//   last pad check; each digit is a store read then an output load, which waits for room.
// Reset: aresetn synchronous, active low; idles the controller, empties the output register.
module integer_to_ascii_formatter_unit #(
    parameter int VALUE_BITS = i2a_pkg::VALUE_BITS_DEF,
    parameter int MAX_WIDTH  = i2a_pkg::MAX_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  i2a_pkg::in_req_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output i2a_pkg::out_req_t m_data
);
    import i2a_pkg::*;

    // command and status bundles between controller and datapath
    cmd_t    cmd;
    status_t sts;

    // The controller owns sequencing only; all arithmetic, counts and the
    // output register sit in the datapath.
    i2a_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    // Digits come out least significant first, go into the digit store and
    // are read back most significant first. A request's text is capped at
    // MAX_RESULTS characters, the last of which carries the last flag.
    i2a_dpath #(
        .VALUE_BITS(VALUE_BITS),
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dpath (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_data (s_data),
        .cmd    (cmd),
        .sts    (sts),
        .m_ready(m_ready),
        .m_valid(m_valid),
        .m_data (m_data)
    );

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for integer_to_ascii_formatter_unit, with a text predictor and checker.
module testbench;
    import i2a_pkg::*;

    // Clock, reset and the two request channels. Every input has a known value at time zero.
    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    in_req_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    out_req_t m_data;

    // Characters still owed by the block, oldest first.
    out_req_t expected_chars[$];
    int       error_count = 0;

    // Sender pacing: bursts of random length separated by random gaps.
    // With pacing_on cleared the sender offers requests back to back.
    int       burst_left = 0;
    bit       pacing_on  = 1'b1;

    // Receiver stall pattern. A test asks for a long hold-off through hold_cycles_req;
    // the receiver process takes the request over and counts it down by itself.
    int       hold_cycles_req = 0;
    int       hold_left       = 0;
    int       stall_mode      = 0;
    int       stall_run       = 0;
    int       stall_phase     = 0;

    localparam string DIGIT_SET = "0123456789ABCDEF";

    integer_to_ascii_formatter_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Hard limit, several times the slowest legal run.
    initial begin
        #(10_000_000);
        $display("[integer_to_ascii_formatter_unit] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Text predictor: the characters that one request must produce.
    // ------------------------------------------------------------------
    function automatic void predict_text(input in_req_t req);
        out_req_t    chars[$];
        out_req_t    c;
        logic [31:0] mag;
        int unsigned base;
        int          field;
        int          ndig;
        logic [3:0]  digits[32];

        mag   = req.value;
        field = int'(req.min_width);
        case (radix_t'(req.radix_code))
            RADIX_BIN: base = 2;
            RADIX_OCT: base = 8;
            RADIX_DEC: base = 10;
            default:   base = 16;
        endcase

        // Signed negative: minus first, then the magnitude, and one column less to fill.
        // The most negative value negates to itself, which is the right unsigned magnitude.
        c.last = 1'b0;
        if (req.signed_mode && mag[31]) begin
            c.text_char = CHAR_MINUS;
            chars.push_back(c);
            mag = -mag;
            if (field != 0) field--;
        end

        // Least significant digit first; zero still gives one digit.
        ndig = 0;
        do begin
            digits[ndig] = 4'(mag % base);
            mag          = mag / base;
            ndig++;
        end while (mag != 0);

        for (int n = field - ndig; n > 0; n--) begin
            c.text_char = req.pad_char;
            chars.push_back(c);
        end
        for (int i = ndig - 1; i >= 0; i--) begin
            c.text_char = DIGIT_SET[digits[i]];
            chars.push_back(c);
        end

        // Output is capped; the final character kept carries last.
        while (chars.size() > MAX_RESULTS) void'(chars.pop_back());
        chars[chars.size() - 1].last = 1'b1;
        foreach (chars[k]) expected_chars.push_back(chars[k]);
    endfunction

    function automatic in_req_t make_request(input logic [31:0] value, input radix_t radix,
                                             input logic sgn, input logic [5:0] width,
                                             input logic [7:0] pad);
        in_req_t req;
        req.value       = value;
        req.radix_code  = radix;
        req.signed_mode = sgn;
        req.min_width   = width;
        req.pad_char    = pad;
        return req;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got 'h%0h expected 'h%0h", $time, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // Send one request. Called at a rising edge; returns at the rising edge that
    // accepted it with s_valid still high, or after the pacing gap with s_valid low.
    // Handshakes are sampled at the falling edge, where everything has settled to
    // the values the next rising edge will see.
    // ------------------------------------------------------------------
    task automatic send_request(input in_req_t req);
        int gap;
        s_valid <= 1'b1;
        s_data  <= req;
        do @(negedge aclk); while (!s_ready);
        predict_text(req);
        @(posedge aclk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 9);
            gap        = pacing_on ? $urandom_range(0, 8) : 0;
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Sender pauses until every owed character has come out.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: changes its stall mode every so often, plus the long hold-off.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_cycles_req != 0) begin
            hold_left       = hold_cycles_req;
            hold_cycles_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (stall_run == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_run  = $urandom_range(20, 200);
            end
            stall_run--;
            stall_phase++;
            case (stall_mode)
                0:       m_ready <= 1'b1;                          // never stalls
                1:       m_ready <= 1'($urandom_range(0, 1));
                2:       m_ready <= (stall_phase % 5) < 3;          // fixed rhythm
                default: m_ready <= ($urandom_range(0, 3) == 0);    // mostly stalled
            endcase
        end
    end

    // Checker: each accepted character against the oldest one owed.
    always @(negedge aclk) begin
        out_req_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch("unexpected character", int'(m_data.text_char), 0);
            end else begin
                want = expected_chars.pop_front();
                if (m_data.text_char !== want.text_char)
                    report_mismatch("text_char", int'(m_data.text_char),
                                    int'(want.text_char));
                if (m_data.last !== want.last)
                    report_mismatch("last", int'(m_data.last), int'(want.last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero gives a single '0' in every radix, padded as usual.
    task automatic test_zero_values();
        send_request(make_request(32'd0, RADIX_BIN, 1'b0, 6'd0, " "));
        send_request(make_request(32'd0, RADIX_OCT, 1'b1, 6'd0, " "));
        send_request(make_request(32'd0, RADIX_DEC, 1'b0, 6'd5, "0"));
        send_request(make_request(32'd0, RADIX_HEX, 1'b1, 6'd3, " "));
    endtask

    // All ones and the sign boundary, in both modes; unsigned mode must not see a sign.
    task automatic test_extreme_values();
        send_request(make_request(32'hFFFF_FFFF, RADIX_BIN, 1'b0, 6'd0, " "));
        send_request(make_request(32'hFFFF_FFFF, RADIX_DEC, 1'b0, 6'd0, " "));
        send_request(make_request(32'hFFFF_FFFF, RADIX_OCT, 1'b0, 6'd0, " "));
        send_request(make_request(32'hFFFF_FFFF, RADIX_DEC, 1'b1, 6'd0, " "));
        send_request(make_request(32'h8000_0000, RADIX_DEC, 1'b1, 6'd0, " "));
        send_request(make_request(32'h8000_0000, RADIX_BIN, 1'b1, 6'd0, " "));
        send_request(make_request(32'h8000_0000, RADIX_DEC, 1'b0, 6'd0, " "));
        send_request(make_request(32'h7FFF_FFFF, RADIX_DEC, 1'b1, 6'd0, " "));
    endtask

    // Every hex and octal digit shows up.
    task automatic test_digit_set();
        send_request(make_request(32'hDEAD_BEEF, RADIX_HEX, 1'b0, 6'd0, " "));
        send_request(make_request(32'h0123_4567, RADIX_HEX, 1'b0, 6'd0, " "));
        send_request(make_request(32'o12345670, RADIX_OCT, 1'b0, 6'd0, " "));
        send_request(make_request(32'h89AB_CDEF, RADIX_HEX, 1'b0, 6'd0, " "));
    endtask

    // Padding: full width, sign eating a column, widths at or below the digit count,
    // and pad characters at the ends of the byte range.
    task automatic test_padding();
        send_request(make_request(32'd7, RADIX_DEC, 1'b0, 6'd63, "*"));
        send_request(make_request(-32'sd31, RADIX_HEX, 1'b1, 6'd63, "0"));
        send_request(make_request(-32'sd42, RADIX_DEC, 1'b1, 6'd0, " "));
        send_request(make_request(-32'sd42, RADIX_DEC, 1'b1, 6'd1, " "));
        send_request(make_request(32'd1000, RADIX_DEC, 1'b0, 6'd4, "#"));
        send_request(make_request(32'd98765, RADIX_DEC, 1'b0, 6'd1, " "));
        send_request(make_request(32'd5, RADIX_BIN, 1'b0, 6'd10, 8'hFF));
        send_request(make_request(32'd9, RADIX_HEX, 1'b1, 6'd3, 8'h00));
    endtask

    // Receiver holds off for a long stretch while requests keep coming, so the
    // block fills and stops taking input; then a full drain before carrying on.
    task automatic test_output_backpressure();
        pacing_on       = 1'b0;
        burst_left      = 20;
        hold_cycles_req = 400;
        for (int i = 0; i < 12; i++)
            send_request(make_request($urandom, radix_t'($urandom_range(0, 3)),
                                      1'($urandom_range(0, 1)), 6'($urandom_range(0, 20)),
                                      "0"));
        pacing_on = 1'b1;
        wait_for_drain();
    endtask

    // Random requests: values skewed to short numbers as often as full range, widths
    // mostly small, pad mostly space or zero. Stretches without sender gaps and
    // occasional drains are mixed in.
    task automatic test_random_requests(input int count);
        in_req_t req;
        int      pick;
        for (int i = 0; i < count; i++) begin
            if (i % 60 == 0) pacing_on = ($urandom_range(0, 3) != 0);
            if (i % 90 == 89) wait_for_drain();

            pick = $urandom_range(0, 3);
            case (pick)
                0:       req.value = $urandom;
                1:       req.value = $urandom_range(0, 20);
                2:       req.value = -32'($urandom_range(0, 300));
                default: req.value = $urandom >> $urandom_range(0, 31);
            endcase
            req.radix_code  = 2'($urandom_range(0, 3));
            req.signed_mode = 1'($urandom_range(0, 1));
            req.min_width   = ($urandom_range(0, 6) == 0) ? 6'($urandom_range(0, 63))
                                                          : 6'($urandom_range(0, 12));
            pick = $urandom_range(0, 9);
            req.pad_char    = (pick < 4) ? 8'h20 : (pick < 7) ? CHAR_ZERO : 8'($urandom);
            send_request(req);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_zero_values();
        test_extreme_values();
        test_digit_set();
        test_padding();
        test_output_backpressure();
        test_random_requests(450);

        // Let the last characters out, then allow for anything stray.
        wait_for_drain();
        repeat (64) @(posedge aclk);
        if (expected_chars.size() != 0)
            report_mismatch("characters never sent", expected_chars.size(), 0);

        if (error_count == 0) begin
            $display("[integer_to_ascii_formatter_unit] OK");
        end else begin
            $display("[integer_to_ascii_formatter_unit] ERROR");
        end
        $finish;
    end

endmodule

### files.f
design/i2a_pkg.sv
design/i2a_ram.sv
design/i2a_ctrl.sv
design/i2a_dpath.sv
design/integer_to_ascii_formatter_unit.sv
dv/testbench.sv
